// ----- hw/rtl/wav8s_pkg.sv -----
package wav8s_pkg;

    // Parse phases
    localparam logic [3:0] PH_RIFF_ID  = 4'd0;
    localparam logic [3:0] PH_RIFF_LEN = 4'd1;
    localparam logic [3:0] PH_WAVE     = 4'd2;
    localparam logic [3:0] PH_FMT_ID   = 4'd3;
    localparam logic [3:0] PH_FMT_LEN  = 4'd4;
    localparam logic [3:0] PH_FMT_BAD  = 4'd5;
    localparam logic [3:0] PH_FMT_BODY = 4'd6;
    localparam logic [3:0] PH_FMT_SKIP = 4'd7;
    localparam logic [3:0] PH_DATA_ID  = 4'd8;
    localparam logic [3:0] PH_DATA_LEN = 4'd9;
    localparam logic [3:0] PH_SAMPLES  = 4'd10;
    localparam logic [3:0] PH_DEAD     = 4'd11;

    // Result kinds
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_HDR_OK = 2'd1;
    localparam logic [1:0] KIND_HDR_BAD = 2'd2;

    // Chunk ids, little-endian as they arrive
    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;

    localparam logic [15:0] FMT_PCM      = 16'd1;
    localparam logic [31:0] FMT_BODY_LEN = 32'd16;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [7:0]  sample;
        logic [15:0] channel_count;
        logic [15:0] sample_bits;
        logic [31:0] sample_rate;
    } result_t;

endpackage

// ----- hw/rtl/wav8s_parser.sv -----
module wav8s_parser
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            stream_byte,
    input  logic [31:0]           file_size,
    output wav8s_pkg::result_t    res
);

    logic [3:0]  phase_reg,   phase_next;
    logic [4:0]  cnt_reg,     cnt_next;
    logic [31:0] shift_reg,   shift_next;
    logic [31:0] fmt_len_reg, fmt_len_next;
    logic [31:0] skip_reg,    skip_next;
    logic [15:0] fmt_code_reg, fmt_code_next;
    logic [15:0] chan_reg,    chan_next;
    logic [15:0] bits_reg,    bits_next;
    logic [31:0] rate_reg,    rate_next;
    logic [23:0] gather_reg,  gather_next;
    logic [1:0]  gidx_reg,    gidx_next;

    logic [31:0] shift_new;
    logic [31:0] skip_dec;
    logic        last4;
    logic        mono;
    logic        eight;
    logic [1:0]  need_m1;
    logic [7:0]  b0, b1, b2;
    logic [8:0]  sum8;
    logic [16:0] sum16;
    logic [15:0] v1, v2;

    assign shift_new = {stream_byte, shift_reg[31:8]};
    assign skip_dec  = skip_reg - 32'd1;
    assign last4     = (cnt_reg[1:0] == 2'b11);
    assign mono      = (chan_reg == 16'd1);
    assign eight     = (bits_reg == 16'd8);
    assign b0        = gather_reg[7:0];
    assign b1        = gather_reg[15:8];
    assign b2        = gather_reg[23:16];
    assign sum8      = {1'b0, b0} + {1'b0, stream_byte};
    assign v1        = {b1 ^ 8'h80, b0};
    assign v2        = {stream_byte ^ 8'h80, b2};
    assign sum16     = {1'b0, v1} + {1'b0, v2};

    always_comb
    begin
        // frame size minus one
        if (mono)
            need_m1 = eight ? 2'd0 : 2'd1;
        else
            need_m1 = eight ? 2'd1 : 2'd3;
    end

    always_comb
    begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        shift_next    = shift_reg;
        fmt_len_next  = fmt_len_reg;
        skip_next     = skip_reg;
        fmt_code_next = fmt_code_reg;
        chan_next     = chan_reg;
        bits_next     = bits_reg;
        rate_next     = rate_reg;
        gather_next   = gather_reg;
        gidx_next     = gidx_reg;

        res.valid         = 1'b0;
        res.kind          = wav8s_pkg::KIND_SAMPLE;
        res.sample        = 8'd0;
        res.channel_count = chan_reg;
        res.sample_bits   = bits_reg;
        res.sample_rate   = rate_reg;

        if (phase_reg == wav8s_pkg::PH_DEAD)
        begin
            // silent until reset
        end
        else if (phase_reg == wav8s_pkg::PH_SAMPLES)
        begin
            if (gidx_reg < need_m1)
            begin
                gather_next = gather_reg | ({16'd0, stream_byte} << {gidx_reg, 3'b000});
                gidx_next   = gidx_reg + 2'd1;
            end
            else
            begin
                res.valid = 1'b1;
                if (need_m1 == 2'd0)
                    res.sample = stream_byte;
                else if (need_m1 == 2'd1 && mono)
                    res.sample = stream_byte ^ 8'h80;
                else if (need_m1 == 2'd1)
                    res.sample = sum8[8:1];
                else
                    res.sample = sum16[16:9];
                gather_next = 24'd0;
                gidx_next   = 2'd0;
            end
        end
        else
        begin
            shift_next = shift_new;
            cnt_next   = cnt_reg + 5'd1;
            unique case (phase_reg)
                wav8s_pkg::PH_RIFF_ID:
                begin
                    if (last4)
                    begin
                        cnt_next = 5'd0;
                        if (shift_new != wav8s_pkg::ID_RIFF)
                        begin
                            phase_next = wav8s_pkg::PH_DEAD;
                            res.valid  = 1'b1;
                            res.kind   = wav8s_pkg::KIND_HDR_BAD;
                        end
                        else
                            phase_next = wav8s_pkg::PH_RIFF_LEN;
                    end
                end
                wav8s_pkg::PH_RIFF_LEN:
                begin
                    if (last4)
                    begin
                        cnt_next = 5'd0;
                        if (shift_new > file_size)
                        begin
                            phase_next = wav8s_pkg::PH_DEAD;
                            res.valid  = 1'b1;
                            res.kind   = wav8s_pkg::KIND_HDR_BAD;
                        end
                        else
                            phase_next = wav8s_pkg::PH_WAVE;
                    end
                end
                wav8s_pkg::PH_WAVE:
                begin
                    if (last4)
                    begin
                        cnt_next = 5'd0;
                        if (shift_new != wav8s_pkg::ID_WAVE)
                        begin
                            phase_next = wav8s_pkg::PH_DEAD;
                            res.valid  = 1'b1;
                            res.kind   = wav8s_pkg::KIND_HDR_BAD;
                        end
                        else
                            phase_next = wav8s_pkg::PH_FMT_ID;
                    end
                end
                wav8s_pkg::PH_FMT_ID:
                begin
                    if (last4)
                    begin
                        cnt_next   = 5'd0;
                        phase_next = (shift_new == wav8s_pkg::ID_FMT) ?
                                     wav8s_pkg::PH_FMT_LEN : wav8s_pkg::PH_FMT_BAD;
                    end
                end
                wav8s_pkg::PH_FMT_LEN:
                begin
                    if (last4)
                    begin
                        cnt_next     = 5'd0;
                        fmt_len_next = shift_new;
                        phase_next   = (shift_new >= wav8s_pkg::FMT_BODY_LEN) ?
                                       wav8s_pkg::PH_FMT_BODY : wav8s_pkg::PH_DATA_ID;
                    end
                end
                wav8s_pkg::PH_FMT_BAD:
                begin
                    if (last4)
                    begin
                        cnt_next   = 5'd0;
                        phase_next = wav8s_pkg::PH_DATA_ID;
                    end
                end
                wav8s_pkg::PH_FMT_BODY:
                begin
                    if (cnt_reg == 5'd1)
                        fmt_code_next = shift_new[31:16];
                    else if (cnt_reg == 5'd3 && fmt_code_reg == wav8s_pkg::FMT_PCM)
                        chan_next = shift_new[31:16];
                    else if (cnt_reg == 5'd7 && fmt_code_reg == wav8s_pkg::FMT_PCM)
                        rate_next = shift_new;
                    else if (cnt_reg == 5'd15)
                    begin
                        if (fmt_code_reg == wav8s_pkg::FMT_PCM)
                            bits_next = shift_new[31:16];
                        skip_next  = fmt_len_reg - wav8s_pkg::FMT_BODY_LEN;
                        cnt_next   = 5'd0;
                        phase_next = (fmt_len_reg != wav8s_pkg::FMT_BODY_LEN) ?
                                     wav8s_pkg::PH_FMT_SKIP : wav8s_pkg::PH_DATA_ID;
                    end
                    else if (cnt_reg > 5'd15)
                    begin
                        cnt_next   = 5'd0;
                        phase_next = wav8s_pkg::PH_DATA_ID;
                    end
                end
                wav8s_pkg::PH_FMT_SKIP:
                begin
                    skip_next = skip_dec;
                    cnt_next  = 5'd0;
                    if (skip_dec == 32'd0)
                        phase_next = wav8s_pkg::PH_DATA_ID;
                end
                wav8s_pkg::PH_DATA_ID:
                begin
                    if (last4)
                    begin
                        cnt_next = 5'd0;
                        if (shift_new != wav8s_pkg::ID_DATA)
                        begin
                            phase_next = wav8s_pkg::PH_DEAD;
                            res.valid  = 1'b1;
                            res.kind   = wav8s_pkg::KIND_HDR_BAD;
                        end
                        else
                            phase_next = wav8s_pkg::PH_DATA_LEN;
                    end
                end
                wav8s_pkg::PH_DATA_LEN:
                begin
                    if (last4)
                    begin
                        cnt_next    = 5'd0;
                        phase_next  = wav8s_pkg::PH_SAMPLES;
                        gather_next = 24'd0;
                        gidx_next   = 2'd0;
                        res.valid   = 1'b1;
                        res.kind    = wav8s_pkg::KIND_HDR_OK;
                    end
                end
                default:
                begin
                    cnt_next   = 5'd0;
                    phase_next = wav8s_pkg::PH_DEAD;
                end
            endcase
        end

        if (!accept)
            res.valid = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= wav8s_pkg::PH_RIFF_ID;
            cnt_reg      <= 5'd0;
            shift_reg    <= 32'd0;
            fmt_len_reg  <= 32'd0;
            skip_reg     <= 32'd0;
            fmt_code_reg <= 16'd0;
            chan_reg     <= 16'd0;
            bits_reg     <= 16'd0;
            rate_reg     <= 32'd0;
            gather_reg   <= 24'd0;
            gidx_reg     <= 2'd0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            shift_reg    <= shift_next;
            fmt_len_reg  <= fmt_len_next;
            skip_reg     <= skip_next;
            fmt_code_reg <= fmt_code_next;
            chan_reg     <= chan_next;
            bits_reg     <= bits_next;
            rate_reg     <= rate_next;
            gather_reg   <= gather_next;
            gidx_reg     <= gidx_next;
        end
    end

endmodule

// ----- hw/rtl/wav_stream_to_8bit_sampler_top.sv -----
// WAV byte stream to unsigned 8-bit mono sampler.
//
// Input channel (in_valid/in_ready/stream_byte): the WAV file, one byte per
// transfer, in file order. The RIFF/WAVE header and fmt chunk are parsed on
// the fly; after the data chunk header, each sample frame becomes one 8-bit
// sample (16-bit data sign-flipped, high byte; stereo averaged).
// Output channel (out_valid/out_ready): kind, sample and the latched
// channel_count, sample_bits, sample_rate. One "header accepted" result at
// the data chunk, one "header rejected" result on a bad RIFF/WAVE/data id
// or oversized RIFF length; later bytes are swallowed until reset.
// Config channel (cfg_valid/cfg_ready/file_size): largest allowed RIFF
// length; cfg_ready is always high. Write only while idle.
// Throughput: one byte per cycle while in_ready is high. A result is
// registered into the output register, or into the skid while that is held.
// The parser state advances in one registered pass per byte.
// Stall: a two-entry output (output register plus skid) takes one result
// while the receiver stalls, in_ready staying high; in_ready drops only
// while the skid holds a result.
// Reset: parser waits for "RIFF", held format fields are zero, file_size
// returns to all ones, output is empty.
module wav_stream_to_8bit_sampler_top
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  stream_byte,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  sample,
    output logic [15:0] channel_count,
    output logic [15:0] sample_bits,
    output logic [31:0] sample_rate,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] file_size
);

    logic [31:0]          file_size_reg;
    logic                 in_fire;
    logic                 out_fire;
    wav8s_pkg::result_t   res;
    wav8s_pkg::result_t   out_reg;
    wav8s_pkg::result_t   skid_reg;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_reg.valid;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_reg.valid && out_ready;

    // Config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            file_size_reg <= 32'hFFFF_FFFF;
        else if (cfg_valid)
            file_size_reg <= file_size;
    end

    wav8s_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_fire),
        .stream_byte (stream_byte),
        .file_size   (file_size_reg),
        .res         (res)
    );

    // Output register + skid. res.valid is only set on an accepted byte,
    // which cannot happen while the skid is full.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg  <= '0;
            skid_reg <= '0;
        end
        else
        begin
            if (res.valid)
            begin
                if (!out_reg.valid || out_fire)
                    out_reg <= res;
                else
                    skid_reg <= res;
            end
            else if (out_fire)
            begin
                if (skid_reg.valid)
                begin
                    out_reg        <= skid_reg;
                    skid_reg.valid <= 1'b0;
                end
                else
                    out_reg.valid <= 1'b0;
            end
        end
    end

    assign out_valid     = out_reg.valid;
    assign kind          = out_reg.kind;
    assign sample        = out_reg.sample;
    assign channel_count = out_reg.channel_count;
    assign sample_bits   = out_reg.sample_bits;
    assign sample_rate   = out_reg.sample_rate;

endmodule
